### rtl/nps_pkg.sv
// shared types, constants and helpers of the nearest pixel scatter resize block
// no dependencies; imported by the controller, the datapath and the top level
package nps_pkg;

  localparam int DIM_W     = 16;   // width of every dimension and coordinate
  localparam int PIX_W     = 8;    // one component byte
  localparam int NCOMP     = 4;    // components carried in one word
  localparam int IDX_W     = 32;   // destination pixel index
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;
  localparam int IN_W      = NCOMP * PIX_W;
  localparam int OUT_W     = 2 * DIM_W + IDX_W + NCOMP * PIX_W;
  localparam int STEP_W    = $clog2(DIM_W);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SRC_W   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_H   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_POW2    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TGT_W   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TGT_H   = 3'd5;

  // controller to datapath commands
  typedef struct packed {
    logic load;       // take the input word, clamp counters, advance them
    logic mul_x;      // dw * col
    logic mul_y;      // dh * row
    logic div_init;   // load both divider lanes from the products
    logic div_step;   // one quotient bit on both lanes
    logic idx;        // dy * dw + dx
    logic out_load;   // move the finished result into the output register
  } cmd_t;

  // largest power of two not above v; 1 for zero
  function automatic logic [DIM_W-1:0] pow2_floor(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = {{(DIM_W-1){1'b0}}, 1'b1};
    for (int i = 0; i < DIM_W; i++) begin
      if (v[i]) begin
        r    = '0;
        r[i] = 1'b1;
      end
    end
    return r;
  endfunction

endpackage

### rtl/nps_ctrl.sv
// sequencer of the resize block: steps one pixel through multiply, divide and index
// depends on nps_pkg; drives the datapath by cmd_t only
module nps_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  output logic          out_tvalid,
  input  logic          out_tready,
  output nps_pkg::cmd_t cmd
);
  import nps_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MULX,
    S_MULY,
    S_DINIT,
    S_DIV,
    S_IDX,
    S_DONE
  } state_t;

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              slot_free;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign slot_free  = !out_valid_r || out_tready;

  always_comb begin
    cmd          = '0;
    cmd.load     = (state_r == S_IDLE) && in_tvalid;
    cmd.mul_x    = (state_r == S_MULX);
    cmd.mul_y    = (state_r == S_MULY);
    cmd.div_init = (state_r == S_DINIT);
    cmd.div_step = (state_r == S_DIV);
    cmd.idx      = (state_r == S_IDX);
    cmd.out_load = (state_r == S_DONE) && slot_free;
  end

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_MULX;
        end
      end
      S_MULX:  state_nxt = S_MULY;
      S_MULY:  state_nxt = S_DINIT;
      S_DINIT: begin
        state_nxt = S_DIV;
        step_nxt  = '0;
      end
      S_DIV: begin
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_W'(DIM_W - 1)) begin
          state_nxt = S_IDX;
        end
      end
      S_IDX:   state_nxt = S_DONE;
      S_DONE: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // once a word is taken the block is busy until its result is queued
  a_busy_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> !in_tready)
    else $error("input taken twice for one item");

  // the output register is only overwritten when empty or being drained
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_tready))
    else $error("result overwrote a pending word");

  // a new result only appears from the final state
  a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result raised outside the final state");

  // the divider runs exactly its full step count
  a_div_length: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDX) |-> $past(state_r == S_DIV) && $past(step_r) == STEP_W'(DIM_W - 1))
    else $error("divider left early");

endmodule

### rtl/nps_datapath.sv
// datapath of the resize block: config registers, counters, shared multiplier,
// two-lane shift-subtract divider and the output register; depends on nps_pkg
module nps_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  input  logic [nps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [nps_pkg::CFG_DAT_W-1:0] cfg_data,
  input  logic [nps_pkg::IN_W-1:0]      in_tdata,
  input  nps_pkg::cmd_t                 cmd,
  output logic [nps_pkg::OUT_W-1:0]     out_tdata,
  output logic                          out_tlast
);
  import nps_pkg::*;

  // configuration
  logic [DIM_W-1:0] src_w_r, src_h_r, tgt_w_r, tgt_h_r;
  logic             alpha_r, pow2_r;

  // frame position
  logic [DIM_W-1:0] col_cnt_r, row_cnt_r;

  // per item working registers
  logic [DIM_W-1:0]       col_r, row_r, dw_r, dh_r;
  logic [NCOMP*PIX_W-1:0] pix_r;
  logic                   last_r;
  logic [IDX_W-1:0]       px_r, py_r, idx_r;
  logic [2*DIM_W-1:0]     lane_x_r, lane_y_r;   // {remainder, numerator low / quotient}

  logic [DIM_W-1:0]   sw, sh, col_c, row_c;
  logic               last_col, last_row;
  logic [DIM_W-1:0]   mul_a, mul_b;
  logic [IDX_W-1:0]   prod;
  logic [PIX_W-1:0]   alpha_byte;

  logic [OUT_W-1:0] out_data_r;
  logic             out_last_r;

  // one restoring step: shift in the next numerator bit, subtract when it fits
  function automatic logic [2*DIM_W-1:0] div_step(input logic [2*DIM_W-1:0] lane,
                                                  input logic [DIM_W-1:0]   d);
    logic [DIM_W:0]   t;
    logic             ge;
    logic [DIM_W-1:0] rem;
    t   = {lane[2*DIM_W-1:DIM_W], lane[DIM_W-1]};
    ge  = (t >= {1'b0, d});
    rem = ge ? DIM_W'(t - {1'b0, d}) : t[DIM_W-1:0];
    return {rem, lane[DIM_W-2:0], ge};
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r <= DIM_W'(1);
      src_h_r <= DIM_W'(1);
      alpha_r <= 1'b0;
      pow2_r  <= 1'b1;
      tgt_w_r <= DIM_W'(1);
      tgt_h_r <= DIM_W'(1);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SRC_W: src_w_r <= cfg_data;
        REG_SRC_H: src_h_r <= cfg_data;
        REG_ALPHA: alpha_r <= cfg_data[0];
        REG_POW2:  pow2_r  <= cfg_data[0];
        REG_TGT_W: tgt_w_r <= cfg_data;
        REG_TGT_H: tgt_h_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // zero source size acts as one; a stale counter is pulled to the last place
  assign sw       = (src_w_r == '0) ? DIM_W'(1) : src_w_r;
  assign sh       = (src_h_r == '0) ? DIM_W'(1) : src_h_r;
  assign col_c    = (col_cnt_r < sw) ? col_cnt_r : sw - 1'b1;
  assign row_c    = (row_cnt_r < sh) ? row_cnt_r : sh - 1'b1;
  assign last_col = (col_c == sw - 1'b1);
  assign last_row = (row_c == sh - 1'b1);
  assign alpha_byte = alpha_r ? in_tdata[NCOMP*PIX_W-1 -: PIX_W] : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
    end else if (cmd.load) begin
      if (last_col) begin
        col_cnt_r <= '0;
        row_cnt_r <= last_row ? '0 : row_c + 1'b1;
      end else begin
        col_cnt_r <= col_c + 1'b1;
        row_cnt_r <= row_c;
      end
    end
  end

  // single shared multiplier
  assign mul_a = cmd.mul_y ? dh_r : dw_r;
  assign mul_b = cmd.mul_x ? col_r : (cmd.mul_y ? row_r : lane_y_r[DIM_W-1:0]);
  assign prod  = IDX_W'(mul_a * mul_b);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      col_r  <= col_c;
      row_r  <= row_c;
      dw_r   <= pow2_r ? pow2_floor(src_w_r) : tgt_w_r;
      dh_r   <= pow2_r ? pow2_floor(src_h_r) : tgt_h_r;
      pix_r  <= {alpha_byte, in_tdata[(NCOMP-1)*PIX_W-1:0]};
      last_r <= last_col && last_row;
    end
    if (cmd.mul_x) begin
      px_r <= prod;
    end
    if (cmd.mul_y) begin
      py_r <= prod;
    end
    // product < divisor << DIM_W, so the upper half already sits below the divisor
    if (cmd.div_init) begin
      lane_x_r <= px_r;
      lane_y_r <= py_r;
    end else if (cmd.div_step) begin
      lane_x_r <= div_step(lane_x_r, sw);
      lane_y_r <= div_step(lane_y_r, sh);
    end
    if (cmd.idx) begin
      idx_r <= prod + {{(IDX_W-DIM_W){1'b0}}, lane_x_r[DIM_W-1:0]};
    end
    if (cmd.out_load) begin
      out_data_r <= {pix_r, idx_r, lane_y_r[DIM_W-1:0], lane_x_r[DIM_W-1:0]};
      out_last_r <= last_r;
    end
  end

  assign out_tdata = out_data_r;
  assign out_tlast = out_last_r;

endmodule

### rtl/nearest_pixel_scatter_resize.sv
// Nearest-neighbor scatter resize. Source pixels arrive in raster order, one word per
// pixel; each gives one destination write with dest_x = dw*col/sw, dest_y = dh*row/sh
// (floor), dest_index = dest_x + dest_y*dw and the pixel bytes. tlast marks the last
// pixel of a frame. With pow2_mode set, dw and dh are the largest powers of two not
// above the source size, otherwise the target registers. After acceptance a pixel passes
// through the shared multiplier for the two scaled products, a divider load, the
// shift-subtract divider (both axes side by side), a multiply-add for the index and
// the hand-over into the output register. The next word is taken only once the block
// is idle again after the hand-over. The output register lets the next pixel start
// while a result waits; the hand-over state holds only while the previous result is
// still waiting there. Configuration may be written whenever no pixel is in flight.
// depends on nps_pkg, nps_ctrl and nps_datapath
module nearest_pixel_scatter_resize (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration write channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [nps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [nps_pkg::CFG_DAT_W-1:0] cfg_data,
  // pixel input
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [nps_pkg::IN_W-1:0]      in_tdata,   // comp0, comp1, comp2, comp3
  // destination writes
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [nps_pkg::OUT_W-1:0]     out_tdata,  // dest_x, dest_y, dest_index,
                                                    // out0, out1, out2, out3
  output logic                          out_tlast   // frame_last
);
  import nps_pkg::*;

  cmd_t cmd;

  assign cfg_ready = 1'b1;

  nps_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  nps_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tdata  (in_tdata),
    .cmd       (cmd),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

endmodule
